FILE: src/weekly_setpoint_scheduler_macros.svh
// assertion macros used by the scheduler sequencer rtl
// needs a clock named clk and a reset named rst in the module that uses them
`ifndef WEEKLY_SETPOINT_SCHEDULER_MACROS_SVH
`define WEEKLY_SETPOINT_SCHEDULER_MACROS_SVH

// property must hold at every clock edge outside reset
`define WSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define WSS_ASSERT_NEVER(lbl, cond, msg) \
  `WSS_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/wss_pkg.sv
// shared types and constants for the weekly setpoint scheduler
// no dependencies
package wss_pkg;

  localparam int unsigned DAYS_DEF      = 7;
  localparam int unsigned SLOTS_DEF     = 48;

  localparam int unsigned OP_W          = 2;
  localparam int unsigned DAY_W         = 3;
  localparam int unsigned HOUR_W        = 5;
  localparam int unsigned MIN_W         = 6;
  localparam int unsigned MASK_W        = 7;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned TEMP_W        = 9;
  localparam int unsigned VAL_W         = 8;

  localparam logic [TEMP_W-1:0] BASE_TENTHS = 9'd100;
  localparam logic [MIN_W-1:0]  HALF_HOUR   = 6'd30;
  localparam logic [TEMP_W-1:0] VAL_MAX     = 9'd255;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_MODE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_READ,
    S_SHOW
  } state_t;

endpackage

FILE: src/wss_mem.sv
// schedule table storage: one write port, one registered read port
// depends on wss_pkg
module wss_mem #(
  parameter int unsigned DEPTH = 336
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [wss_pkg::VAL_W-1:0]    wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [wss_pkg::VAL_W-1:0]    rdata
);
  import wss_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/wss_seq.sv
// sequencer: decodes words, sweeps the table for clear and fill, reads back the current slot
// depends on wss_pkg and weekly_setpoint_scheduler_macros.svh
`include "weekly_setpoint_scheduler_macros.svh"

module wss_seq #(
  parameter int unsigned DAYS          = 7,
  parameter int unsigned SLOTS_PER_DAY = 48
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  output logic                                        busy,
  output logic                                        done,
  input  logic [wss_pkg::OP_W-1:0]                    op,
  input  logic                                        program_mode,
  input  logic [wss_pkg::DAY_W-1:0]                   week_day,
  input  logic [wss_pkg::HOUR_W-1:0]                  hour,
  input  logic [wss_pkg::MIN_W-1:0]                   minute,
  input  logic [wss_pkg::MASK_W-1:0]                  day_mask,
  input  logic [wss_pkg::SLOT_W-1:0]                  from_slot,
  input  logic [wss_pkg::SLOT_W-1:0]                  to_slot,
  input  logic [wss_pkg::TEMP_W-1:0]                  temp_tenths,
  output logic [wss_pkg::TEMP_W-1:0]                  target_tenths,
  output logic                                        power_on,
  output logic                                        mem_we,
  output logic [$clog2(DAYS*SLOTS_PER_DAY)-1:0]       mem_waddr,
  output logic [wss_pkg::VAL_W-1:0]                   mem_wdata,
  output logic                                        mem_re,
  output logic [$clog2(DAYS*SLOTS_PER_DAY)-1:0]       mem_raddr,
  input  logic [wss_pkg::VAL_W-1:0]                   mem_rdata
);
  import wss_pkg::*;

  localparam int unsigned DEPTH = DAYS * SLOTS_PER_DAY;
  localparam int unsigned AW    = $clog2(DEPTH);

  state_t state, state_next;

  logic [AW-1:0]     base, base_next;
  logic [DAY_W-1:0]  day_cnt, day_cnt_next;
  logic [SLOT_W-1:0] slot_cnt, slot_cnt_next;
  logic [MASK_W-1:0] fill_mask, fill_mask_next;
  logic [SLOT_W-1:0] fill_from, fill_from_next;
  logic [SLOT_W-1:0] fill_to, fill_to_next;
  logic [VAL_W-1:0]  fill_val, fill_val_next;
  logic [DAY_W-1:0]  last_day, last_day_next;
  logic [SLOT_W-1:0] last_slot, last_slot_next;
  logic              last_known, last_known_next;
  logic              in_range, in_range_next;

  logic              accept;
  logic [SLOT_W-1:0] tick_slot;
  logic [SLOT_W-1:0] to_clamped;
  logic [TEMP_W-1:0] temp_diff;
  logic [VAL_W-1:0]  edit_val;
  logic              last_in_range;
  logic              next_day;
  logic [VAL_W-1:0]  shown;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign tick_slot = {hour, (minute >= HALF_HOUR)};
  assign to_clamped = (to_slot > SLOT_W'(SLOTS_PER_DAY - 1)) ?
                      SLOT_W'(SLOTS_PER_DAY - 1) : to_slot;
  assign temp_diff = temp_tenths - BASE_TENTHS;
  assign edit_val  = (op_t'(op) != OP_ADD || temp_tenths < BASE_TENTHS) ? '0 :
                     (temp_diff > VAL_MAX) ? '1 : temp_diff[VAL_W-1:0];
  assign last_in_range = (last_day < DAY_W'(DAYS)) && (last_slot < SLOT_W'(SLOTS_PER_DAY));

  // shared address adder: row base plus slot, used by clear and fill
  assign mem_waddr = base + AW'(slot_cnt);
  assign mem_wdata = (state == S_CLEAR) ? '0 : fill_val;
  assign mem_raddr = AW'(last_day) * AW'(SLOTS_PER_DAY) + AW'(last_slot);

  assign shown         = in_range ? mem_rdata : '0;
  assign target_tenths = (done && shown != '0) ? TEMP_W'(shown) + BASE_TENTHS : '0;
  assign power_on      = done && (shown != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      day_cnt    <= '0;
      slot_cnt   <= '0;
      last_day   <= '0;
      last_slot  <= '0;
      last_known <= 1'b0;
    end else begin
      base       <= base_next;
      day_cnt    <= day_cnt_next;
      slot_cnt   <= slot_cnt_next;
      last_day   <= last_day_next;
      last_slot  <= last_slot_next;
      last_known <= last_known_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_mask <= fill_mask_next;
    fill_from <= fill_from_next;
    fill_to   <= fill_to_next;
    fill_val  <= fill_val_next;
    in_range  <= in_range_next;
  end

  always_comb begin
    state_next      = state;
    base_next       = base;
    day_cnt_next    = day_cnt;
    slot_cnt_next   = slot_cnt;
    fill_mask_next  = fill_mask;
    fill_from_next  = fill_from;
    fill_to_next    = fill_to;
    fill_val_next   = fill_val;
    last_day_next   = last_day;
    last_slot_next  = last_slot;
    last_known_next = last_known;
    in_range_next   = in_range;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    done            = 1'b0;
    next_day        = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (base == AW'(DEPTH - 1)) begin
          base_next  = '0;
          state_next = S_IDLE;
        end else begin
          base_next = base + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_TICK: begin
              if (program_mode &&
                  !(last_known && tick_slot == last_slot && week_day == last_day)) begin
                last_day_next   = week_day;
                last_slot_next  = tick_slot;
                last_known_next = 1'b1;
                state_next      = S_READ;
              end
            end
            OP_ADD, OP_REMOVE: begin
              fill_mask_next = day_mask;
              fill_from_next = from_slot;
              fill_to_next   = to_clamped;
              fill_val_next  = edit_val;
              day_cnt_next   = '0;
              base_next      = '0;
              slot_cnt_next  = from_slot;
              state_next     = S_FILL;
            end
            OP_MODE: begin
              last_known_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        if (day_cnt == DAY_W'(DAYS)) begin
          base_next     = '0;
          slot_cnt_next = '0;
          state_next    = last_known ? S_READ : S_IDLE;
        end else if (fill_mask[day_cnt] && slot_cnt <= fill_to) begin
          mem_we = 1'b1;
          if (slot_cnt == fill_to) begin
            next_day = 1'b1;
          end else begin
            slot_cnt_next = slot_cnt + 1'b1;
          end
        end else begin
          // day not selected or empty range
          next_day = 1'b1;
        end
        if (next_day) begin
          day_cnt_next  = day_cnt + 1'b1;
          base_next     = base + AW'(SLOTS_PER_DAY);
          slot_cnt_next = fill_from;
        end
      end
      S_READ: begin
        mem_re        = last_in_range;
        in_range_next = last_in_range;
        state_next    = S_SHOW;
      end
      S_SHOW: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `WSS_ASSERT(a_show_follows_read, done |-> $past(state) == S_READ, "result without table read")
  `WSS_ASSERT(a_mode_forgets, (accept && op == OP_MODE) |=> !last_known,
              "mode change kept last slot")
  `WSS_ASSERT(a_repeat_tick_silent,
              (accept && op == OP_TICK && last_known && tick_slot == last_slot &&
               week_day == last_day) |=> !busy, "repeated slot started a read")
  `WSS_ASSERT_NEVER(a_write_in_table, mem_we && (int'(mem_waddr) >= DEPTH),
                    "table write beyond last entry")

endmodule

FILE: src/weekly_setpoint_scheduler.sv
// top level of the weekly setpoint scheduler
// depends on wss_pkg, wss_seq and wss_mem
//
// After reset the block sweeps the whole table to off, one entry per cycle, and holds busy
// high until the sweep ends, before it takes its first word. A tick that reports a slot
// goes through a table read state and then a show state with busy high, and shows the
// result with done in the show state; a tick with nothing to report leaves busy low. An
// edit walks the days one after another through the single table write port, skipping a
// day with nothing to write and otherwise writing its selected slots in turn, and then
// reads and shows the result through the read and show states when a current slot is known.
// done is high for exactly one cycle and the receiver cannot hold it off: target_tenths and
// power_on must be taken in that cycle.
module weekly_setpoint_scheduler #(
  parameter int unsigned DAYS          = wss_pkg::DAYS_DEF,
  parameter int unsigned SLOTS_PER_DAY = wss_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic [wss_pkg::OP_W-1:0]       op,
  input  logic                           program_mode,
  input  logic [wss_pkg::DAY_W-1:0]      week_day,
  input  logic [wss_pkg::HOUR_W-1:0]     hour,
  input  logic [wss_pkg::MIN_W-1:0]      minute,
  input  logic [wss_pkg::MASK_W-1:0]     day_mask,
  input  logic [wss_pkg::SLOT_W-1:0]     from_slot,
  input  logic [wss_pkg::SLOT_W-1:0]     to_slot,
  input  logic [wss_pkg::TEMP_W-1:0]     temp_tenths,
  output logic [wss_pkg::TEMP_W-1:0]     target_tenths,
  output logic                           power_on
);
  import wss_pkg::*;

  localparam int unsigned DEPTH = DAYS * SLOTS_PER_DAY;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  wss_seq #(
    .DAYS          (DAYS),
    .SLOTS_PER_DAY (SLOTS_PER_DAY)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .op            (op),
    .program_mode  (program_mode),
    .week_day      (week_day),
    .hour          (hour),
    .minute        (minute),
    .day_mask      (day_mask),
    .from_slot     (from_slot),
    .to_slot       (to_slot),
    .temp_tenths   (temp_tenths),
    .target_tenths (target_tenths),
    .power_on      (power_on),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  wss_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
